### rtl/core/fdf_pkg.sv
// Shared types and constants for the fixed frame byte deframer.
// No dependencies.
package fdf_pkg;

	localparam int BYTE_W    = 8;
	localparam int WORD_W    = 32;
	localparam int IDX_W     = 4;
	localparam int FILL_W    = 6;
	localparam int CNT_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int LANES     = WORD_W / BYTE_W;

	localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAIL   = 2'd1;

	localparam logic [BYTE_W-1:0] HEADER_RST = 8'hAA;
	localparam logic [BYTE_W-1:0] TAIL_RST   = 8'h55;

	typedef enum logic [1:0] {
		S_HUNT,
		S_COLLECT,
		S_READ,
		S_LOAD
	} state_t;

	typedef struct packed {
		logic store_first;
		logic store_byte;
		logic end_frame;
		logic rd_issue;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic hdr_hit;
		logic frame_end;
		logic frame_ok;
		logic last_idx;
		logic out_free;
	} sts_t;

endpackage

### rtl/core/fdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fdf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 12
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/fdf_ctrl.sv
// Deframer controller: hunt, collect, and word drain sequencing.
// Depends on fdf_pkg.
module fdf_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output fdf_pkg::cmd_t cmd,
	input  fdf_pkg::sts_t sts
);

	import fdf_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_HUNT: begin
				in_ready = 1'b1;
				if (in_valid && sts.hdr_hit) begin
					cmd.store_first = 1'b1;
					state_d         = S_COLLECT;
				end
			end
			S_COLLECT: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.store_byte = 1'b1;
					if (sts.frame_end) begin
						cmd.end_frame = 1'b1;
						state_d       = sts.frame_ok ? S_READ : S_HUNT;
					end
				end
			end
			S_READ: begin
				if (sts.out_free) begin
					cmd.rd_issue = 1'b1;
					state_d      = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load_out = 1'b1;
				state_d      = sts.last_idx ? S_HUNT : S_READ;
			end
			default: state_d = S_HUNT;
		endcase
	end

endmodule

### rtl/core/fdf_dpath.sv
// Deframer datapath: config registers, fill counter, word packing into the
// frame store, frame check, valid-frame count and output register.
// Depends on fdf_pkg and fdf_ram.
module fdf_dpath #(
	parameter int FRAME_BYTES = 46,
	parameter int WORD_COUNT  = 11
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fdf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fdf_pkg::BYTE_W-1:0]       cfg_data,
	input  logic [fdf_pkg::BYTE_W-1:0]       rx_byte,
	input  fdf_pkg::cmd_t                    cmd,
	output fdf_pkg::sts_t                    sts,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [fdf_pkg::WORD_W-1:0]       word_value,
	output logic [fdf_pkg::IDX_W-1:0]        word_index,
	output logic                             last_word,
	output logic [fdf_pkg::CNT_W-1:0]        frame_count
);

	import fdf_pkg::*;

	// Payload bytes 1..FRAME_BYTES-1 packed four to a store word
	localparam int FRAME_WORDS = (FRAME_BYTES + 2) / 4;
	localparam int AW          = $clog2(FRAME_WORDS);

	logic [BYTE_W-1:0]           header_q, tail_q, byte0_q;
	logic [FILL_W-1:0]           fill_q;
	logic [2:0][BYTE_W-1:0]      acc_q;
	logic [IDX_W-1:0]            idx_q;
	logic [CNT_W-1:0]            valid_frames_q;
	logic                        out_valid_q;
	logic [WORD_W-1:0]           word_q;
	logic [IDX_W-1:0]            index_q;
	logic                        last_q;
	logic [CNT_W-1:0]            count_q;

	logic [FILL_W-1:0]           pos_m1;
	logic [1:0]                  lane;
	logic [LANES-1:0][BYTE_W-1:0] wdata;
	logic                        wr_en;
	logic [AW-1:0]               waddr;
	logic [WORD_W-1:0]           rdata;
	logic                        idx_in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RST;
			tail_q   <= TAIL_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_HEADER) begin
				header_q <= cfg_data;
			end else if (cfg_index == CFG_TAIL) begin
				tail_q <= cfg_data;
			end
		end
	end

	assign pos_m1 = fill_q - FILL_W'(1);
	assign lane   = pos_m1[1:0];
	assign waddr  = pos_m1[AW+1:2];
	assign wr_en  = cmd.store_byte && (lane == 2'd3 || sts.frame_end);

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (2'(j) < lane) begin
				wdata[j] = acc_q[j];
			end else if (2'(j) == lane) begin
				wdata[j] = rx_byte;
			end else begin
				wdata[j] = '0;
			end
		end
		wdata[3] = (lane == 2'd3) ? rx_byte : '0;
	end

	assign sts.hdr_hit   = rx_byte == header_q;
	assign sts.frame_end = fill_q == FILL_W'(FRAME_BYTES - 1);
	assign sts.frame_ok  = byte0_q == header_q && rx_byte == tail_q;
	assign sts.last_idx  = idx_q == IDX_W'(WORD_COUNT - 1);
	assign sts.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q         <= '0;
			idx_q          <= '0;
			valid_frames_q <= '0;
		end else begin
			if (cmd.store_first) begin
				fill_q <= FILL_W'(1);
			end else if (cmd.end_frame) begin
				fill_q <= '0;
			end else if (cmd.store_byte) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			if (cmd.end_frame) begin
				idx_q <= '0;
				if (sts.frame_ok) begin
					valid_frames_q <= valid_frames_q + CNT_W'(1);
				end
			end else if (cmd.load_out) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store_first) begin
			byte0_q <= rx_byte;
		end
		if (cmd.store_byte && lane != 2'd3) begin
			acc_q[lane] <= rx_byte;
		end
	end

	assign idx_in_range = {1'b0, idx_q} < (IDX_W + 1)'(FRAME_WORDS);

	fdf_ram #(
		.WIDTH(WORD_W),
		.DEPTH(FRAME_WORDS)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd_issue),
		.raddr(idx_q[AW-1:0]),
		.rdata(rdata)
	);

	// Output register; words past the stored payload read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			word_q  <= idx_in_range ? rdata : '0;
			index_q <= idx_q;
			last_q  <= sts.last_idx;
			count_q <= valid_frames_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign word_value  = word_q;
	assign word_index  = index_q;
	assign last_word   = last_q;
	assign frame_count = count_q;

endmodule

### rtl/core/fixed_frame_byte_deframer.sv
// Top level of the fixed frame byte deframer.
// Depends on fdf_pkg, fdf_ctrl, fdf_dpath (and fdf_ram below it).
//
// Usage:
//   Input channel in_valid/in_ready carries one rx_byte per transfer.
//   While hunting, bytes other than the header byte are dropped. A frame is
//   FRAME_BYTES bytes including the header; its last byte must equal the
//   tail byte, else the frame is discarded and hunting resumes.
//   Output channel out_valid/out_ready carries WORD_COUNT words per good
//   frame: word_value (little-endian from bytes 1+4i..4+4i), word_index,
//   last_word and frame_count (good frames so far, wrapping).
//   Config: cfg_we with cfg_index 0 (header byte) or 1 (tail byte); other
//   indexes are ignored. Write only while idle.
// Timing:
//   Bytes are taken one per cycle while collecting. After the tail byte
//   transfer, each word is read from the frame store, then loaded into the
//   output register. Input is held off during the drain.
// Reset: header 0xAA, tail 0x55, good-frame counter zero, hunting, no output.
// Stalls: a held output word pauses the drain; the word stays on the port.
module fixed_frame_byte_deframer #(
	parameter int FRAME_BYTES = 46,
	parameter int WORD_COUNT  = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fdf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fdf_pkg::BYTE_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [fdf_pkg::BYTE_W-1:0]    rx_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fdf_pkg::WORD_W-1:0]    word_value,
	output logic [fdf_pkg::IDX_W-1:0]     word_index,
	output logic                          last_word,
	output logic [fdf_pkg::CNT_W-1:0]     frame_count
);

	import fdf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	fdf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd     (cmd),
		.sts     (sts)
	);

	fdf_dpath #(
		.FRAME_BYTES(FRAME_BYTES),
		.WORD_COUNT (WORD_COUNT)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.rx_byte    (rx_byte),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.word_value (word_value),
		.word_index (word_index),
		.last_word  (last_word),
		.frame_count(frame_count)
	);

endmodule

### bench/tb_fixed_frame_byte_deframer.sv
// Testbench for fixed_frame_byte_deframer: directed and random byte streams with bursty input
// and a stalling sink, checked word by word against a frame predictor kept in the bench.
// Depends on fdf_pkg and the deframer RTL.
module tb_fixed_frame_byte_deframer;
	import fdf_pkg::*;

	localparam int FRAME_BYTES = 46;
	localparam int WORD_COUNT  = 11;
	localparam int DRAIN_GAP   = 2 * WORD_COUNT + 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_CAP   = 40;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_MARKS} fill_t;
	typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SLOW, SINK_LONG} sink_t;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic [IDX_W-1:0]  index;
		logic              last;
		logic [CNT_W-1:0]  count;
	} frame_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BYTE_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [BYTE_W-1:0]    rx_byte = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [WORD_W-1:0]    word_value;
	logic [IDX_W-1:0]     word_index;
	logic                 last_word;
	logic [CNT_W-1:0]     frame_count;

	fixed_frame_byte_deframer #(
		.FRAME_BYTES(FRAME_BYTES),
		.WORD_COUNT (WORD_COUNT)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.word_value (word_value),
		.word_index (word_index),
		.last_word  (last_word),
		.frame_count(frame_count)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// frame predictor state
	logic [BYTE_W-1:0] hdr_cfg = HEADER_RST;
	logic [BYTE_W-1:0] tail_cfg = TAIL_RST;
	logic [FILL_W-1:0] fill_level = '0;
	logic [BYTE_W-1:0] frame_bytes [64];
	logic [CNT_W-1:0]  good_frames = '0;
	int                frames_dropped = 0;
	frame_word_t       expected_words [$];

	logic [BYTE_W-1:0] tx_bytes [$];
	int                mismatches = 0;
	int                bytes_taken = 0;
	int                words_seen = 0;
	int                cycle_count = 0;

	function automatic logic [BYTE_W-1:0] held_byte(int pos);
		if (pos >= FRAME_BYTES)
			return '0;
		return frame_bytes[pos];
	endfunction

	task automatic apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
		case (idx)
			CFG_HEADER: hdr_cfg = val;
			CFG_TAIL:   tail_cfg = val;
			default:    ;
		endcase
	endtask

	task automatic absorb_byte(logic [BYTE_W-1:0] b);
		frame_word_t w;
		int          p;
		int          i;
		if (fill_level == 0 && b != hdr_cfg)
			return;
		frame_bytes[fill_level] = b;
		fill_level = fill_level + 1'b1;
		if (fill_level < FRAME_BYTES)
			return;
		fill_level = '0;
		// both checks use the registers as they stand when the frame completes
		if (held_byte(0) != hdr_cfg || held_byte(FRAME_BYTES - 1) != tail_cfg) begin
			frames_dropped++;
			return;
		end
		good_frames = good_frames + 1'b1;
		for (i = 0; i < WORD_COUNT; i++) begin
			p = 1 + 4 * i;
			w.value = {held_byte(p + 3), held_byte(p + 2), held_byte(p + 1), held_byte(p)};
			w.index = IDX_W'(i);
			w.last  = (i == WORD_COUNT - 1);
			w.count = good_frames;
			expected_words.push_back(w);
		end
	endtask

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	// input driver: bursts of transfers separated by random gaps
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!in_valid || in_ready) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (tx_bytes.size() > 0) begin
				in_valid <= 1'b1;
				rx_byte <= tx_bytes.pop_front();
				if (burst_left > 1) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(1, 48);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output sink: stall pattern re-drawn at random from the four sink modes
	sink_t sink_mode = SINK_OPEN;
	int    sink_hold = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_mode <= SINK_OPEN;
			sink_hold <= 0;
		end else begin
			if (cycle_count % 200 == 0)
				sink_mode <= sink_t'($urandom_range(0, 3));
			case (sink_mode)
				SINK_OPEN: out_ready <= 1'b1;
				SINK_COIN: out_ready <= 1'($urandom_range(0, 1));
				SINK_SLOW: out_ready <= (cycle_count % 4 == 0);
				default: begin
					if (sink_hold > 0) begin
						out_ready <= 1'b0;
						sink_hold <= sink_hold - 1;
					end else begin
						out_ready <= 1'b1;
						if ($urandom_range(0, 7) == 0)
							sink_hold <= $urandom_range(4, 16);
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// monitor: register writes and byte transfers feed the predictor, words are checked
	always @(posedge clk) begin : watch_ports
		frame_word_t want;
		if (arst_n) begin
			if (cfg_we)
				apply_cfg(cfg_index, cfg_data);
			if (in_valid && in_ready) begin
				bytes_taken++;
				absorb_byte(rx_byte);
			end
			if (out_valid && out_ready) begin
				words_seen++;
				if (expected_words.size() == 0) begin
					flag_mismatch("word with no frame pending", word_value, '0);
				end else begin
					want = expected_words.pop_front();
					if (word_value !== want.value)
						flag_mismatch("word_value", word_value, want.value);
					if (word_index !== want.index)
						flag_mismatch("word_index", word_index, want.index);
					if (last_word !== want.last)
						flag_mismatch("last_word", last_word, want.last);
					if (frame_count !== want.count)
						flag_mismatch("frame_count", frame_count, want.count);
				end
			end
		end
	end

	function automatic bit quiet();
		return tx_bytes.size() == 0 && !in_valid && expected_words.size() == 0;
	endfunction

	task automatic settle();
		do @(negedge clk); while (!quiet());
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_frame(logic [BYTE_W-1:0] head_b, logic [BYTE_W-1:0] tail_b,
		fill_t fill);
		logic [BYTE_W-1:0] b;
		int                k;
		tx_bytes.push_back(head_b);
		for (k = 0; k < FRAME_BYTES - 2; k++) begin
			case (fill)
				FILL_ZERO: b = '0;
				FILL_ONES: b = '1;
				FILL_MARKS: begin
					if ($urandom_range(0, 1))
						b = $urandom_range(0, 1) ? head_b : tail_b;
					else
						b = BYTE_W'($urandom);
				end
				default: b = BYTE_W'($urandom);
			endcase
			tx_bytes.push_back(b);
		end
		tx_bytes.push_back(tail_b);
	endtask

	// random bytes that never equal avoid_b
	task automatic queue_noise(int n, logic [BYTE_W-1:0] avoid_b);
		logic [BYTE_W-1:0] b;
		repeat (n) begin
			b = BYTE_W'($urandom);
			if (b == avoid_b)
				b = b ^ 8'h01;
			tx_bytes.push_back(b);
		end
	endtask

	task automatic queue_random_stream(int n);
		int goal;
		int pick;
		goal = tx_bytes.size() + n;
		while (tx_bytes.size() < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 58) begin
				queue_frame(hdr_cfg, tail_cfg, FILL_RANDOM);
			end else if (pick < 70) begin
				queue_frame(hdr_cfg, tail_cfg ^ BYTE_W'($urandom_range(1, 255)), FILL_RANDOM);
			end else if (pick < 80) begin
				queue_noise($urandom_range(1, 8), hdr_cfg);
			end else if (pick < 88) begin
				queue_frame(hdr_cfg, tail_cfg, FILL_MARKS);
			end else if (pick < 94) begin
				// header followed by a short run: the next frame gets swallowed
				tx_bytes.push_back(hdr_cfg);
				queue_noise($urandom_range(1, 30), ~hdr_cfg);
			end else begin
				repeat ($urandom_range(1, 12)) tx_bytes.push_back(BYTE_W'($urandom));
			end
		end
	endtask

	task automatic flush_partial();
		if (fill_level != 0)
			repeat (FRAME_BYTES - fill_level) tx_bytes.push_back('0);
	endtask

	initial begin : stimulus
		logic [BYTE_W-1:0] v;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset values of both registers
		@(negedge clk);
		tx_bytes.push_back(8'h00);
		tx_bytes.push_back(8'hFF);
		queue_noise(3, HEADER_RST);
		queue_frame(HEADER_RST, TAIL_RST, FILL_ZERO);
		queue_frame(HEADER_RST, TAIL_RST, FILL_ONES);
		queue_frame(HEADER_RST, 8'h54, FILL_RANDOM);
		settle();

		// writes to unused indexes must leave both registers alone
		write_reg(CFG_SPARE_A, 8'h00);
		write_reg(CFG_SPARE_B, 8'hFF);
		@(negedge clk);
		queue_frame(HEADER_RST, TAIL_RST, FILL_RANDOM);
		settle();

		// register changes while a frame is half collected
		@(negedge clk);
		flush_partial();
		tx_bytes.push_back(HEADER_RST);
		repeat (20) tx_bytes.push_back(BYTE_W'($urandom));
		settle();
		write_reg(CFG_HEADER, 8'h3C);
		@(negedge clk);
		repeat (FRAME_BYTES - 22) tx_bytes.push_back(BYTE_W'($urandom));
		tx_bytes.push_back(TAIL_RST);
		tx_bytes.push_back(8'h3C);
		repeat (10) tx_bytes.push_back(BYTE_W'($urandom));
		settle();
		write_reg(CFG_TAIL, 8'h99);
		@(negedge clk);
		repeat (FRAME_BYTES - 12) tx_bytes.push_back(BYTE_W'($urandom));
		tx_bytes.push_back(8'h99);
		settle();

		write_reg(CFG_HEADER, 8'h00);
		write_reg(CFG_TAIL, 8'hFF);
		@(negedge clk);
		queue_random_stream(10);
		settle();

		write_reg(CFG_HEADER, 8'hFF);
		write_reg(CFG_TAIL, 8'h00);
		@(negedge clk);
		queue_random_stream(10);
		settle();

		write_reg(CFG_HEADER, BYTE_W'($urandom));
		write_reg(CFG_TAIL, BYTE_W'($urandom));
		@(negedge clk);
		queue_random_stream(10);
		settle();

		// header and tail equal
		v = BYTE_W'($urandom);
		write_reg(CFG_HEADER, v);
		write_reg(CFG_TAIL, v);
		@(negedge clk);
		queue_random_stream(10);
		settle();

		$display("Sent %0d bytes under 7 register settings: %0d good and %0d rejected frames,",
			bytes_taken, good_frames, frames_dropped);
		$display("%0d words checked, %0d mismatches", words_seen, mismatches);
		if (mismatches == 0 && expected_words.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### sim.f
rtl/core/fdf_pkg.sv
rtl/core/fdf_ram.sv
rtl/core/fdf_ctrl.sv
rtl/core/fdf_dpath.sv
rtl/core/fixed_frame_byte_deframer.sv
bench/tb_fixed_frame_byte_deframer.sv
